[design/gfa_pkg.sv]
// Shared types and constants for the GF(2^8) field arithmetic unit.
package gfa_pkg;

  localparam logic [2:0] OP_ADD    = 3'd0;
  localparam logic [2:0] OP_XTIME  = 3'd1;
  localparam logic [2:0] OP_MUL    = 3'd2;
  localparam logic [2:0] OP_INV    = 3'd3;
  localparam logic [2:0] OP_PARITY = 3'd4;
  localparam logic [2:0] OP_ROR    = 3'd5;

  localparam logic [7:0] POLY_RESET     = 8'h1B;
  localparam logic [7:0] INV_STEP_LIMIT = 8'd255;

  typedef struct packed {
    logic [2:0] opcode;
    logic [7:0] operand_a;
    logic [7:0] operand_b;
    logic [7:0] shift_count;
  } gfa_in_t;

  typedef struct packed {
    logic [7:0] result;
    logic       error;
  } gfa_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_XTIME,
    ST_MUL,
    ST_INV,
    ST_DONE
  } gfa_state_e;

endpackage

[design/gf256_field_alu.sv]
// Top level of the GF(2^8) field arithmetic unit with its sequencer.
//
//   Channel   Direction  Handshake                 Payload
//   in        input      in_valid_i / in_stall_o   in_word_i   (gfa_in_t)
//   out       output     out_valid_o / out_stall_i out_word_o  (gfa_out_t)
//   cfg       input      cfg_we_i                  cfg_wdata_i (reduction polynomial)
//
// Add, parity, rotate and unused codes form their result at accept and go to done.
// Repeated xtime applies the step unit shift_count times; multiply steps it until
// no upper bit of b is left. Inverse multiplies each power by a through the one
// step unit, at most 255 multiplications per word.
// Reset clears the sequencer and the output valid and loads the AES polynomial.
// A new word is taken while a result waits on a stalled output; the next result
// waits in the done state until the output register is free.
module gf256_field_alu
  import gfa_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  gfa_in_t  in_word_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output gfa_out_t out_word_o,
  input  logic     cfg_we_i,
  input  logic [7:0] cfg_wdata_i
);

  gfa_state_e state_q, state_d;
  logic [7:0] poly_q;
  logic [2:0] op_q, op_d;
  logic [7:0] a_q, a_d;
  logic [7:0] run_q, run_d;
  logic [7:0] acc_q, acc_d;
  logic [7:0] rest_q, rest_d;
  logic [7:0] power_q, power_d;
  logic [7:0] cnt_q, cnt_d;
  logic [7:0] res_q, res_d;
  logic       err_q, err_d;
  logic       out_valid_q, out_valid_d;
  gfa_out_t   out_q, out_d;

  logic [7:0] run_nx, acc_nx;
  logic       in_fire, out_free, mul_done, inv_stop;

  gfa_step u_step (
    .run_i  (run_q),
    .acc_i  (acc_q),
    .add_i  (rest_q[1]),
    .poly_i (poly_q),
    .run_o  (run_nx),
    .acc_o  (acc_nx)
  );

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_fire     = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign mul_done    = (rest_q[7:1] == 7'd0);
  // The product is in acc_q once the multiplier has run out of upper bits.
  assign inv_stop    = (acc_q == 8'd0) || (acc_q == 8'd1) ||
                       (cnt_q == INV_STEP_LIMIT - 8'd1);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (in_word_i.opcode)
            OP_XTIME: state_d = ST_XTIME;
            OP_MUL:   state_d = ST_MUL;
            OP_INV:   state_d = (in_word_i.operand_a == 8'd0) ? ST_DONE : ST_INV;
            default:  state_d = ST_DONE;
          endcase
        end
      end
      ST_XTIME: if (cnt_q == 8'd0) state_d = ST_DONE;
      ST_MUL:   if (mul_done) state_d = ST_DONE;
      ST_INV:   if (mul_done && inv_stop) state_d = ST_DONE;
      ST_DONE:  if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    op_d        = op_q;
    a_d         = a_q;
    run_d       = run_q;
    acc_d       = acc_q;
    rest_d      = rest_q;
    power_d     = power_q;
    cnt_d       = cnt_q;
    res_d       = res_q;
    err_d       = err_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          op_d  = in_word_i.opcode;
          a_d   = in_word_i.operand_a;
          err_d = 1'b0;
          res_d = 8'd0;
          unique case (in_word_i.opcode)
            OP_ADD:    res_d = in_word_i.operand_a ^ in_word_i.operand_b;
            OP_XTIME: begin
              run_d = in_word_i.operand_a;
              cnt_d = in_word_i.shift_count;
            end
            OP_MUL: begin
              run_d  = in_word_i.operand_a;
              acc_d  = in_word_i.operand_b[0] ? in_word_i.operand_a : 8'd0;
              rest_d = in_word_i.operand_b;
            end
            OP_INV: begin
              power_d = in_word_i.operand_a;
              run_d   = in_word_i.operand_a;
              acc_d   = in_word_i.operand_a[0] ? in_word_i.operand_a : 8'd0;
              rest_d  = in_word_i.operand_a;
              cnt_d   = 8'd0;
            end
            OP_PARITY: res_d = {7'd0, ^in_word_i.operand_a};
            OP_ROR:    res_d = {in_word_i.operand_a[0], in_word_i.operand_a[7:1]};
            default:   res_d = 8'd0;
          endcase
        end
      end
      ST_XTIME: begin
        if (cnt_q == 8'd0) begin
          res_d = run_q;
        end else begin
          run_d = run_nx;
          cnt_d = cnt_q - 8'd1;
        end
      end
      ST_MUL: begin
        if (mul_done) begin
          res_d = acc_q;
        end else begin
          run_d  = run_nx;
          acc_d  = acc_nx;
          rest_d = {1'b0, rest_q[7:1]};
        end
      end
      ST_INV: begin
        if (!mul_done) begin
          run_d  = run_nx;
          acc_d  = acc_nx;
          rest_d = {1'b0, rest_q[7:1]};
        end else if (acc_q == 8'd1) begin
          res_d = power_q;
        end else if (inv_stop) begin
          // Zero power or no convergence within the step limit.
          res_d = 8'd0;
          err_d = 1'b1;
        end else begin
          power_d = acc_q;
          run_d   = acc_q;
          acc_d   = a_q[0] ? acc_q : 8'd0;
          rest_d  = a_q;
          cnt_d   = cnt_q + 8'd1;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_d.result = res_q;
          out_d.error  = err_q;
          out_valid_d  = 1'b1;
        end
      end
      default: begin
        res_d = 8'd0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      poly_q      <= POLY_RESET;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        poly_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    a_q     <= a_d;
    run_q   <= run_d;
    acc_q   <= acc_d;
    rest_q  <= rest_d;
    power_q <= power_d;
    cnt_q   <= cnt_d;
    res_q   <= res_d;
    err_q   <= err_d;
    out_q   <= out_d;
  end

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q != ST_IDLE))
    else $error("sequencer stayed idle after taking a word");

  a_err_only_inverse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && err_q) |-> (op_q == OP_INV))
    else $error("error flagged for an operation other than inverse");

  a_inv_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_INV) |-> (cnt_q != INV_STEP_LIMIT))
    else $error("inverse step count ran past its limit");

  a_done_delivers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && out_free) |=> (out_valid_q && state_q == ST_IDLE))
    else $error("finished result was not moved to the output register");

endmodule

[design/gfa_step.sv]
// Shared datapath step: one xtime with reduction and a conditional accumulate.
module gfa_step (
  input  logic [7:0] run_i,
  input  logic [7:0] acc_i,
  input  logic       add_i,
  input  logic [7:0] poly_i,
  output logic [7:0] run_o,
  output logic [7:0] acc_o
);

  logic [8:0] shifted;

  assign shifted = {run_i, 1'b0};
  // Reduce only when the shift carried out of bit 7.
  assign run_o   = shifted[8] ? (shifted[7:0] ^ poly_i) : shifted[7:0];
  assign acc_o   = add_i ? (acc_i ^ run_o) : acc_i;

endmodule

[bench/testbench.sv]
// Self-checking testbench for the GF(2^8) field arithmetic unit.
`timescale 1ns / 100ps

module testbench;
  import gfa_pkg::*;

  localparam logic [2:0] OP_SPARE6 = 3'd6;
  localparam logic [2:0] OP_SPARE7 = 3'd7;
  localparam int IDLE_CYCLE_LIMIT = 12000;
  localparam int RANDOM_PER_POLY = 200;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  gfa_in_t    in_word = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  gfa_out_t   out_word;
  logic       cfg_we = 1'b0;
  logic [7:0] cfg_wdata = 8'h00;

  // Local copy of the reduction polynomial as the unit should hold it.
  logic [7:0] field_poly = POLY_RESET;
  gfa_out_t   pending_results[$];
  gfa_in_t    pending_ops[$];
  int         error_count = 0;
  int         sender_idle_pct = 20;
  int         receiver_stall_pct = 20;
  int         quiet_cycles = 0;

  gf256_field_alu dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  always #6 clk = ~clk;

  function automatic logic [7:0] rand_byte();
    return 8'($urandom);
  endfunction

  function automatic logic [7:0] gf_double(input logic [7:0] v);
    logic [8:0] w;
    w = {v, 1'b0};
    if (w[8]) w[7:0] = w[7:0] ^ field_poly;
    return w[7:0];
  endfunction

  function automatic logic [7:0] field_product(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    logic [7:0] run;
    acc = b[0] ? a : 8'h00;
    run = a;
    for (int i = 1; i < 8; i++) begin
      run = gf_double(run);
      if (b[i]) acc = acc ^ run;
    end
    return acc;
  endfunction

  // Walks the powers of a until the next one is 1; a zero power or a cycle
  // that never reaches 1 means the polynomial is reducible for this element.
  function automatic logic [7:0] field_reciprocal(input logic [7:0] a, output logic fail);
    logic [7:0] power;
    logic [7:0] nxt;
    fail = 1'b0;
    if (a == 8'h00) return 8'h00;
    power = a;
    for (int k = 0; k < 255; k++) begin
      nxt = field_product(power, a);
      if (nxt == 8'h00) break;
      if (nxt == 8'h01) return power;
      power = nxt;
    end
    fail = 1'b1;
    return 8'h00;
  endfunction

  function automatic gfa_out_t predict_word(input gfa_in_t w);
    gfa_out_t   r;
    logic [7:0] acc;
    r = '0;
    case (w.opcode)
      OP_ADD: r.result = w.operand_a ^ w.operand_b;
      OP_XTIME: begin
        acc = w.operand_a;
        for (int i = 0; i < w.shift_count; i++) acc = gf_double(acc);
        r.result = acc;
      end
      OP_MUL:    r.result = field_product(w.operand_a, w.operand_b);
      OP_INV:    r.result = field_reciprocal(w.operand_a, r.error);
      OP_PARITY: r.result = {7'd0, ^w.operand_a};
      OP_ROR:    r.result = {w.operand_a[0], w.operand_a[7:1]};
      default:   r = '0;
    endcase
    return r;
  endfunction

  function automatic gfa_in_t make_word(input logic [2:0] op, input logic [7:0] a,
                                        input logic [7:0] b, input logic [7:0] n);
    gfa_in_t w;
    w.opcode = op;
    w.operand_a = a;
    w.operand_b = b;
    w.shift_count = n;
    return w;
  endfunction

  // Inverse runs are the slow ones, so they get a smaller share than the other defined codes.
  function automatic gfa_in_t random_word();
    int         pick;
    logic [2:0] op;
    pick = $urandom_range(99);
    if (pick < 15)      op = OP_ADD;
    else if (pick < 30) op = OP_XTIME;
    else if (pick < 50) op = OP_MUL;
    else if (pick < 60) op = OP_INV;
    else if (pick < 75) op = OP_PARITY;
    else if (pick < 90) op = OP_ROR;
    else if (pick < 95) op = OP_SPARE6;
    else                op = OP_SPARE7;
    return make_word(op, rand_byte(), rand_byte(), rand_byte());
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $time, what);
    error_count++;
  endtask

  task automatic send_word(input gfa_in_t w);
    if ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(predict_word(w));
    pending_ops.push_back(w);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_poly(input logic [7:0] value);
    drain_results();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    field_poly = value;
  endtask

  task automatic test_directed_aes();
    send_word(make_word(OP_ADD, 8'h00, 8'h00, rand_byte()));
    send_word(make_word(OP_ADD, 8'hFF, 8'hFF, rand_byte()));
    send_word(make_word(OP_ADD, 8'hAA, 8'h55, rand_byte()));
    send_word(make_word(OP_XTIME, 8'hA5, rand_byte(), 8'd0));
    send_word(make_word(OP_XTIME, 8'h80, rand_byte(), 8'd1));
    send_word(make_word(OP_XTIME, 8'h01, rand_byte(), 8'd255));
    send_word(make_word(OP_XTIME, 8'hFF, rand_byte(), 8'd255));
    send_word(make_word(OP_MUL, 8'h57, 8'h83, rand_byte()));
    send_word(make_word(OP_MUL, 8'hFF, 8'hFF, rand_byte()));
    send_word(make_word(OP_MUL, 8'hC3, 8'h00, rand_byte()));
    send_word(make_word(OP_MUL, 8'h00, 8'h9D, rand_byte()));
    send_word(make_word(OP_MUL, 8'h6E, 8'h01, rand_byte()));
    send_word(make_word(OP_INV, 8'h00, rand_byte(), rand_byte()));
    send_word(make_word(OP_INV, 8'h01, rand_byte(), rand_byte()));
    send_word(make_word(OP_INV, 8'h53, rand_byte(), rand_byte()));
    send_word(make_word(OP_INV, 8'hFF, rand_byte(), rand_byte()));
    send_word(make_word(OP_PARITY, 8'h00, rand_byte(), rand_byte()));
    send_word(make_word(OP_PARITY, 8'hFF, rand_byte(), rand_byte()));
    send_word(make_word(OP_PARITY, 8'h01, rand_byte(), rand_byte()));
    send_word(make_word(OP_ROR, 8'h01, rand_byte(), rand_byte()));
    send_word(make_word(OP_ROR, 8'hFE, rand_byte(), rand_byte()));
    send_word(make_word(OP_SPARE6, 8'hFF, 8'hFF, 8'hFF));
    send_word(make_word(OP_SPARE7, rand_byte(), rand_byte(), rand_byte()));
  endtask

  // With x^8 the powers of x run into zero, with x^8 + x they cycle without
  // ever reaching one, and x + 1 is still a unit modulo x^8.
  task automatic test_reducible_polys();
    write_poly(8'h00);
    send_word(make_word(OP_INV, 8'h02, rand_byte(), rand_byte()));
    send_word(make_word(OP_INV, 8'h03, rand_byte(), rand_byte()));
    send_word(make_word(OP_XTIME, 8'h80, rand_byte(), 8'd1));
    send_word(make_word(OP_MUL, 8'h80, 8'h02, rand_byte()));
    write_poly(8'h02);
    send_word(make_word(OP_INV, 8'h02, rand_byte(), rand_byte()));
    send_word(make_word(OP_INV, 8'h80, rand_byte(), rand_byte()));
    write_poly(8'hFF);
    send_word(make_word(OP_XTIME, 8'h80, rand_byte(), 8'd1));
    send_word(make_word(OP_INV, 8'h80, rand_byte(), rand_byte()));
    send_word(make_word(OP_MUL, 8'hFF, 8'hFF, rand_byte()));
  endtask

  task automatic test_random_traffic();
    logic [7:0] polys[6];
    polys = '{8'h1B, 8'h00, 8'hFF, 8'h02, 8'h00, POLY_RESET};
    polys[4] = rand_byte();
    foreach (polys[p]) begin
      write_poly(polys[p]);
      repeat (RANDOM_PER_POLY) send_word(random_word());
    end
  endtask

  // A long stretch with neither side idling, back to back words.
  task automatic test_back_to_back();
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    repeat (120) send_word(random_word());
    sender_idle_pct = 20;
    receiver_stall_pct = 20;
  endtask

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < receiver_stall_pct);
  end

  always @(posedge clk) begin : check_result
    gfa_out_t want;
    gfa_in_t  src;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result %h with nothing pending", out_word));
      end else begin
        want = pending_results.pop_front();
        src = pending_ops.pop_front();
        if (out_word.result !== want.result)
          report_mismatch($sformatf("op %0d a=%h b=%h n=%0d poly=%h: result %h, want %h",
                                    src.opcode, src.operand_a, src.operand_b,
                                    src.shift_count, field_poly, out_word.result,
                                    want.result));
        if (out_word.error !== want.error)
          report_mismatch($sformatf("op %0d a=%h poly=%h: error %b, want %b",
                                    src.opcode, src.operand_a, field_poly,
                                    out_word.error, want.error));
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_CYCLE_LIMIT) begin
        $display("Timeout: no word moved for %0d cycles", quiet_cycles);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_aes();
    test_reducible_polys();
    test_random_traffic();
    test_back_to_back();
    drain_results();
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[files.f]
design/gfa_pkg.sv
design/gfa_step.sv
design/gf256_field_alu.sv
bench/testbench.sv
